### rtl/core/fba_pkg.sv
`default_nettype none
package fba_pkg;

  localparam int unsigned MAX_FRAMES_DEF  = 65536;
  localparam int unsigned WORD_BITS       = 64;
  localparam int unsigned BIT_W           = 6;
  localparam int unsigned COUNT_W         = 17;
  localparam int unsigned FRAME_W         = 16;
  localparam logic [16:0] FRAME_COUNT_RST = 17'h10000;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_TEST  = 2'd2,
    ACT_FIND  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_EMPTY
  } state_e;

endpackage
`default_nettype wire

### rtl/core/frame_bitmap_allocator.sv
// Bitmap frame allocator: one used/free bit per frame in a word-wide RAM.
// Request channel (in_valid_i / in_stall_o) carries an action and a frame
// number; response channel (out_valid_o / out_stall_i) returns bit_value,
// free_frame, found and range_error, one response per request.
// Set, clear and test read the word in the accept cycle; in ST_RMW, when
// the output is free, they modify, write back and load the response register.
// Find reads one 64-bit word per cycle from the lowest up until a free bit,
// scanning at most ceil(frame_count / 64) words.
// Out-of-range requests and a find over zero frames skip the RAM read.
// One request is in flight at a time; the next may be accepted while the
// previous response still waits in the output register.
// A stalled response holds; the finishing request waits for the register.
// Reset starts a clearing pass over the RAM, one word per cycle over all
// ceil(MAX_FRAMES / 64) words (1024 by default), with in_stall_o high.
// frame_count is written on cfg_valid_i & cfg_ready_o; ready is always high.
`default_nettype none
module frame_bitmap_allocator #(
  parameter int unsigned MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [fba_pkg::COUNT_W-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    in_action_i,
  input  wire logic [fba_pkg::FRAME_W-1:0]   in_frame_number_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               out_bit_value_o,
  output logic [fba_pkg::FRAME_W-1:0]        out_free_frame_o,
  output logic                               out_found_o,
  output logic                               out_range_error_o
);

  localparam int unsigned WB    = fba_pkg::WORD_BITS;
  localparam int unsigned BW    = fba_pkg::BIT_W;
  localparam int unsigned CW    = fba_pkg::COUNT_W;
  localparam int unsigned DEPTH = (MAX_FRAMES + WB - 1) / WB;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = $clog2(DEPTH + 1);
  localparam int unsigned FW    = (AW + BW > CW) ? AW + BW : CW;

  function automatic logic [BW-1:0] lowest_zero(input logic [WB-1:0] w);
    logic [WB-1:0] v;
    logic [BW-1:0] idx;
    v   = ~w;
    idx = '0;
    for (int k = BW - 1; k >= 0; k--) begin
      if ((v & ((64'd1 << (1 << k)) - 64'd1)) == '0) begin
        idx[k] = 1'b1;
        v      = v >> (1 << k);
      end
    end
    return idx;
  endfunction

  fba_pkg::state_e       state_q, state_d;
  fba_pkg::action_e      act_q, act_d;
  logic [fba_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic                  err_q, err_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [CW-1:0]         frame_count_q;

  logic                  out_valid_q, out_bit_q, out_found_q, out_err_q;
  logic [fba_pkg::FRAME_W-1:0] out_free_q;
  logic                  load_out, res_bit, res_found, res_err;
  logic [fba_pkg::FRAME_W-1:0] res_free;

  logic [WB-1:0] mem [DEPTH];
  logic [WB-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WB-1:0] mem_wdata;

  logic [CW-1:0] eff_cnt;
  logic [31:0]   ceil_words;
  logic [SW-1:0] limit;
  logic          out_ready;
  logic [FW-1:0] left, hit_frame;
  logic [WB-1:0] masked, bit_mask;
  logic [BW-1:0] zero_idx;

  assign eff_cnt    = (32'(frame_count_q) > MAX_FRAMES) ? CW'(MAX_FRAMES) : frame_count_q;
  assign ceil_words = (32'(eff_cnt) + 32'(WB - 1)) >> BW;
  assign limit      = (ceil_words < DEPTH) ? SW'(ceil_words) : SW'(DEPTH);
  assign out_ready  = !out_valid_q || !out_stall_i;

  // pad the bits at and above the frame count as used in a partial last word
  assign left      = FW'(eff_cnt) - (FW'(cur_q) << BW);
  assign masked    = (left < FW'(WB)) ? (rdata_q | ~((64'd1 << left[BW-1:0]) - 64'd1))
                                      : rdata_q;
  assign zero_idx  = lowest_zero(masked);
  assign hit_frame = (FW'(cur_q) << BW) | FW'(zero_idx);
  assign bit_mask  = 64'd1 << frame_q[BW-1:0];

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    frame_d   = frame_q;
    err_d     = err_q;
    cur_d     = cur_q;
    load_out  = 1'b0;
    res_bit   = 1'b0;
    res_free  = '0;
    res_found = 1'b0;
    res_err   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      fba_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (cur_q == AW'(DEPTH - 1)) begin
          state_d = fba_pkg::ST_IDLE;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end
      fba_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          act_d   = fba_pkg::action_e'(in_action_i);
          frame_d = in_frame_number_i;
          if (fba_pkg::action_e'(in_action_i) == fba_pkg::ACT_FIND) begin
            if (limit == '0) begin
              err_d   = 1'b0;
              state_d = fba_pkg::ST_EMPTY;
            end else begin
              mem_re  = 1'b1;
              cur_d   = '0;
              state_d = fba_pkg::ST_SCAN;
            end
          end else if (CW'(in_frame_number_i) >= eff_cnt) begin
            err_d   = 1'b1;
            state_d = fba_pkg::ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(in_frame_number_i >> BW);
            cur_d     = mem_raddr;
            state_d   = fba_pkg::ST_RMW;
          end
        end
      end
      fba_pkg::ST_RMW: begin
        if (out_ready) begin
          load_out = 1'b1;
          state_d  = fba_pkg::ST_IDLE;
          case (act_q)
            fba_pkg::ACT_SET: begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q | bit_mask;
            end
            fba_pkg::ACT_CLEAR: begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q & ~bit_mask;
            end
            fba_pkg::ACT_TEST: res_bit = rdata_q[frame_q[BW-1:0]];
            default: ;
          endcase
        end
      end
      fba_pkg::ST_SCAN: begin
        if (masked != '1) begin
          if (out_ready) begin
            load_out  = 1'b1;
            res_found = 1'b1;
            res_free  = hit_frame[fba_pkg::FRAME_W-1:0];
            state_d   = fba_pkg::ST_IDLE;
          end
        end else if (SW'(cur_q) + 1'b1 < limit) begin
          mem_re    = 1'b1;
          mem_raddr = cur_q + 1'b1;
          cur_d     = mem_raddr;
        end else if (out_ready) begin
          load_out = 1'b1;
          state_d  = fba_pkg::ST_IDLE;
        end
      end
      fba_pkg::ST_EMPTY: begin
        if (out_ready) begin
          load_out = 1'b1;
          res_err  = err_q;
          state_d  = fba_pkg::ST_IDLE;
        end
      end
      default: state_d = fba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fba_pkg::ST_CLEAR;
      cur_q         <= '0;
      out_valid_q   <= 1'b0;
      frame_count_q <= fba_pkg::FRAME_COUNT_RST;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      if (cfg_valid_i) begin
        frame_count_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    frame_q <= frame_d;
    err_q   <= err_d;
    if (load_out) begin
      out_bit_q   <= res_bit;
      out_free_q  <= res_free;
      out_found_q <= res_found;
      out_err_q   <= res_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign cfg_ready_o       = 1'b1;
  assign in_stall_o        = (state_q != fba_pkg::ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign out_bit_value_o   = out_bit_q;
  assign out_free_frame_o  = out_free_q;
  assign out_found_o       = out_found_q;
  assign out_range_error_o = out_err_q;

endmodule
`default_nettype wire

### rtl/core/fba_checker.sv
`default_nettype none
module fba_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        out_bit_value_o,
  input wire logic [fba_pkg::FRAME_W-1:0] out_free_frame_o,
  input wire logic                        out_found_o,
  input wire logic                        out_range_error_o
);

  // the clearing pass blocks requests right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("request accepted during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_found_o |-> !out_range_error_o && !out_bit_value_o)
    else $error("find response carries error or bit value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_found_o |-> out_free_frame_o == '0)
    else $error("free frame nonzero without found");

  // a range error leaves every other field clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_range_error_o |-> !out_bit_value_o && !out_found_o &&
    out_free_frame_o == '0)
    else $error("range error response carries other fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_free_frame_o) &&
    $stable(out_found_o) && $stable(out_range_error_o) && $stable(out_bit_value_o))
    else $error("stalled response changed");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);
`default_nettype wire

### bench/frame_bitmap_allocator_tb.sv
`timescale 1ns / 1ps

module frame_bitmap_allocator_tb;

  localparam int unsigned MAP_WORDS = fba_pkg::MAX_FRAMES_DEF / fba_pkg::WORD_BITS;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 60;

  typedef struct packed {
    logic                        bit_value;
    logic [fba_pkg::FRAME_W-1:0] free_frame;
    logic                        found;
    logic                        range_error;
  } outcome_t;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    fba_pkg::action_e            act;
    logic [fba_pkg::COUNT_W-1:0] value;   // frame number for a request, frame count for a write
    bit                          fixed;
    outcome_t                    reply;
  } row_t;

  localparam outcome_t NO_FLAGS     = '0;
  localparam outcome_t BIT_SET      = '{bit_value: 1'b1, default: 0};
  localparam outcome_t OUT_OF_RANGE = '{range_error: 1'b1, default: 0};
  localparam outcome_t FOUND_ZERO   = '{found: 1'b1, default: 0};

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [fba_pkg::COUNT_W-1:0] cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  in_action_i = fba_pkg::ACT_SET;
  logic [fba_pkg::FRAME_W-1:0] in_frame_number_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        out_bit_value_o;
  logic [fba_pkg::FRAME_W-1:0] out_free_frame_o;
  logic                        out_found_o;
  logic                        out_range_error_o;

  frame_bitmap_allocator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_action_i       (in_action_i),
    .in_frame_number_i (in_frame_number_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_bit_value_o   (out_bit_value_o),
    .out_free_frame_o  (out_free_frame_o),
    .out_found_o       (out_found_o),
    .out_range_error_o (out_range_error_o)
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the allocator state
  logic [fba_pkg::WORD_BITS-1:0] shadow_map [MAP_WORDS];
  logic [fba_pkg::COUNT_W-1:0]   shadow_count = fba_pkg::FRAME_COUNT_RST;

  outcome_t    pending_outcomes [$];
  outcome_t    last_outcome;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  int unsigned n_requests = 0;
  int unsigned n_finds = 0;
  int unsigned n_full = 0;
  int unsigned n_range = 0;
  int unsigned n_settings = 0;

  initial begin
    foreach (shadow_map[i]) shadow_map[i] = '0;
  end

  // computes the reply to one request and applies it to the shadow bitmap
  function automatic outcome_t apply_request(fba_pkg::action_e act,
                                             logic [fba_pkg::FRAME_W-1:0] fn);
    outcome_t                      r;
    int unsigned                   limit;
    int unsigned                   nwords;
    int unsigned                   left;
    logic [fba_pkg::WORD_BITS-1:0] word;
    bit                            done;
    r = '0;
    limit = (shadow_count > fba_pkg::MAX_FRAMES_DEF) ? fba_pkg::MAX_FRAMES_DEF : shadow_count;
    if (act == fba_pkg::ACT_FIND) begin
      nwords = (limit + fba_pkg::WORD_BITS - 1) / fba_pkg::WORD_BITS;
      done = 1'b0;
      for (int unsigned w = 0; w < nwords && !done; w++) begin
        word = shadow_map[w];
        left = limit - w * fba_pkg::WORD_BITS;
        // bits past the frame count read as used
        if (left < fba_pkg::WORD_BITS) word |= {fba_pkg::WORD_BITS{1'b1}} << left;
        if (word != {fba_pkg::WORD_BITS{1'b1}}) begin
          for (int unsigned b = 0; b < fba_pkg::WORD_BITS && !done; b++) begin
            if (!word[b]) begin
              r.found = 1'b1;
              r.free_frame = fba_pkg::FRAME_W'(w * fba_pkg::WORD_BITS + b);
              done = 1'b1;
            end
          end
        end
      end
    end else if (fn >= limit) begin
      r.range_error = 1'b1;
    end else begin
      case (act)
        fba_pkg::ACT_SET:   shadow_map[fn[15:6]][fn[5:0]] = 1'b1;
        fba_pkg::ACT_CLEAR: shadow_map[fn[15:6]][fn[5:0]] = 1'b0;
        default:            r.bit_value = shadow_map[fn[15:6]][fn[5:0]];
      endcase
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_request(fba_pkg::action_e act, logic [fba_pkg::FRAME_W-1:0] fn,
                               bit fixed, outcome_t fixed_reply);
    outcome_t    outcome;
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_action_i <= act;
    in_frame_number_i <= fn;
    do @(posedge clk_i); while (in_stall_o);
    outcome = apply_request(act, fn);
    last_outcome = outcome;
    pending_outcomes.push_back(fixed ? fixed_reply : outcome);
    n_requests++;
    if (act == fba_pkg::ACT_FIND) begin
      n_finds++;
      if (!outcome.found) n_full++;
    end
    if (outcome.range_error) n_range++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame_count(logic [fba_pkg::COUNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_count = value;
    n_settings++;
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned sent;
    int unsigned pick;
    int unsigned limit;
    int unsigned span;
    sent = 0;
    while (sent < items) begin
      limit = (shadow_count > fba_pkg::MAX_FRAMES_DEF) ? fba_pkg::MAX_FRAMES_DEF
                                                       : shadow_count;
      // most traffic stays in the low frames, where allocations pile up
      span = (limit < 256) ? limit : 256;
      pick = $urandom_range(0, 99);
      if (span == 0 || pick >= 85) begin
        issue_request(fba_pkg::action_e'($urandom_range(0, 3)),
                      fba_pkg::FRAME_W'($urandom), 1'b0, NO_FLAGS);
        sent++;
      end else if (pick < 45) begin
        // allocate: find the lowest free frame, then claim it
        issue_request(fba_pkg::ACT_FIND, fba_pkg::FRAME_W'($urandom), 1'b0, NO_FLAGS);
        sent++;
        if (last_outcome.found) begin
          issue_request(fba_pkg::ACT_SET, last_outcome.free_frame, 1'b0, NO_FLAGS);
          sent++;
        end
      end else if (pick < 62) begin
        issue_request(fba_pkg::ACT_CLEAR, fba_pkg::FRAME_W'($urandom_range(0, span - 1)),
                      1'b0, NO_FLAGS);
        sent++;
      end else if (pick < 77) begin
        issue_request(fba_pkg::ACT_TEST, fba_pkg::FRAME_W'($urandom_range(0, span - 1)),
                      1'b0, NO_FLAGS);
        sent++;
      end else begin
        issue_request(fba_pkg::ACT_SET, fba_pkg::FRAME_W'($urandom_range(0, span - 1)),
                      1'b0, NO_FLAGS);
        sent++;
      end
    end
  endtask

  // response side: check accepted replies, then pick the next stall
  always @(posedge clk_i) begin
    outcome_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("reply with no request waiting");
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_bit_value_o !== want.bit_value) begin
          $error("bit_value: expected %0d, got %0d", want.bit_value, out_bit_value_o);
          error_count++;
        end
        if (out_free_frame_o !== want.free_frame) begin
          $error("free_frame: expected %0d, got %0d", want.free_frame, out_free_frame_o);
          error_count++;
        end
        if (out_found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found_o);
          error_count++;
        end
        if (out_range_error_o !== want.range_error) begin
          $error("range_error: expected %0d, got %0d", want.range_error, out_range_error_o);
          error_count++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t                        plan [25];
    logic [fba_pkg::COUNT_W-1:0] phase_counts [PHASES];
    plan = '{
      '{ROW_REQUEST, fba_pkg::ACT_TEST,  17'd0,     1'b1, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_TEST,  17'd65535, 1'b1, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_FIND,  17'd12345, 1'b1, FOUND_ZERO},
      '{ROW_REQUEST, fba_pkg::ACT_SET,   17'd0,     1'b1, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_TEST,  17'd0,     1'b1, BIT_SET},
      '{ROW_REQUEST, fba_pkg::ACT_FIND,  17'd65535, 1'b0, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_SET,   17'd65535, 1'b1, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_TEST,  17'd65535, 1'b1, BIT_SET},
      '{ROW_REQUEST, fba_pkg::ACT_CLEAR, 17'd65535, 1'b1, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_TEST,  17'd65535, 1'b1, NO_FLAGS},
      // zero frame count: everything out of range, nothing to find
      '{ROW_WRITE,   fba_pkg::ACT_SET,   17'd0,     1'b0, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_TEST,  17'd0,     1'b1, OUT_OF_RANGE},
      '{ROW_REQUEST, fba_pkg::ACT_CLEAR, 17'd65535, 1'b1, OUT_OF_RANGE},
      '{ROW_REQUEST, fba_pkg::ACT_FIND,  17'd0,     1'b1, NO_FLAGS},
      // count above capacity clamps to the bitmap size
      '{ROW_WRITE,   fba_pkg::ACT_SET,   17'h1FFFF, 1'b0, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_SET,   17'd65535, 1'b0, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_FIND,  17'd0,     1'b0, NO_FLAGS},
      // partial last word
      '{ROW_WRITE,   fba_pkg::ACT_SET,   17'd65,    1'b0, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_SET,   17'd64,    1'b0, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_TEST,  17'd65,    1'b1, OUT_OF_RANGE},
      '{ROW_REQUEST, fba_pkg::ACT_FIND,  17'd0,     1'b0, NO_FLAGS},
      // one frame, already used: nothing free
      '{ROW_WRITE,   fba_pkg::ACT_SET,   17'd1,     1'b0, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_FIND,  17'd0,     1'b1, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_CLEAR, 17'd0,     1'b0, NO_FLAGS},
      '{ROW_REQUEST, fba_pkg::ACT_FIND,  17'd0,     1'b1, FOUND_ZERO}
    };
    phase_counts = '{17'd65536, 17'd100, 17'h1FFFF, 17'd70, 17'd0, 17'd64,
                     fba_pkg::COUNT_W'($urandom_range(2, 300)),
                     fba_pkg::COUNT_W'($urandom_range(0, 131071))};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_frame_count(plan[i].value);
      end else begin
        issue_request(plan[i].act, plan[i].value[fba_pkg::FRAME_W-1:0], plan[i].fixed,
                      plan[i].reply);
      end
    end

    foreach (phase_counts[p]) begin
      // sender holds off until every reply is in before the count changes
      settle();
      write_frame_count(phase_counts[p]);
      calm = ($urandom_range(0, 3) == 0);
      run_phase(PHASE_ITEMS);
    end

    settle();
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests over %0d frame count writes, %0d finds (%0d with nothing free).",
             n_requests, n_settings, n_finds, n_full);
    $display("%0d requests hit the range check; %0d mismatches.", n_range, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### frame_bitmap_allocator.f
rtl/core/fba_pkg.sv
rtl/core/frame_bitmap_allocator.sv
rtl/core/fba_checker.sv
bench/frame_bitmap_allocator_tb.sv
